// File: rtl/distance_amplitude_panner_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the distance amplitude panner
// Implication checks that fall away when the design is synthesised.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_AMPLITUDE_PANNER_ASSERT_SVH
`define DISTANCE_AMPLITUDE_PANNER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define DAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DAP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dap_pkg.sv
// ---------------------------------------------------------------------------
// dap_pkg
// Types, constants and helper functions of the distance amplitude panner.
// ---------------------------------------------------------------------------
package dap_pkg;

	localparam int MAX_SPEAKERS = 16;
	localparam int IDX_W        = $clog2(MAX_SPEAKERS);

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_FOCUS  = 2'd1,
		REG_COUNT  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_RENDER = 1'b1
	} action_t;

	// Side information that travels beside the arithmetic.
	typedef struct packed {
		logic               valid;
		logic [5:0]         chan;
		logic [11:0]        frame;
		logic signed [23:0] sample;
		logic               last;
	} meta_t;

	// State of the digit-by-digit square root.
	typedef struct packed {
		logic [35:0] rad;
		logic [21:0] rem;
		logic [17:0] root;
	} sqrt_t;

	// Two result bits of the square root.
	function automatic sqrt_t sqrt_step(sqrt_t x);
		sqrt_t       y;
		logic [21:0] rem_n;
		logic [21:0] trial;
		y = x;
		for (int i = 0; i < 2; i++) begin
			rem_n = {y.rem[19:0], y.rad[35:34]};
			trial = {2'b00, y.root, 2'b01};
			y.rad = {y.rad[33:0], 2'b00};
			if (rem_n >= trial) begin
				y.rem  = rem_n - trial;
				y.root = {y.root[16:0], 1'b1};
			end else begin
				y.rem  = rem_n;
				y.root = {y.root[16:0], 1'b0};
			end
		end
		return y;
	endfunction

	// Integer square root, evaluated at elaboration only.
	function automatic logic [63:0] const_isqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] val;
		res  = '0;
		val  = v;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bitv > val) bitv = bitv >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bitv != 0) begin
				if (val >= res + bitv) begin
					val = val - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q1.30, k = 1..16.
	function automatic logic [30:0] exp_root(int k);
		logic [63:0] r;
		r = const_isqrt(64'd1 << 59);
		for (int j = 1; j < 16; j++) begin
			if (j < k) r = const_isqrt(r << 30);
		end
		return r[30:0];
	endfunction

endpackage

// File: rtl/distance_amplitude_panner.sv
// ---------------------------------------------------------------------------
// distance_amplitude_panner
// Distance-based amplitude panning over up to sixteen speakers.
// ---------------------------------------------------------------------------
// A load request writes one speaker slot. A render request is expanded by the
// speaker sequencer into one pipeline entry per speaker in use (at most
// sixteen, none when no speaker is in use), one speaker per cycle while the
// output does not stall; the input is held off until the last entry has been
// issued, and the next request can be taken in the cycle after. Each entry
// runs through a 49-stage pipeline (difference, squares, square root two bits
// per stage, log2 by squaring one bit per stage, scaling by focus, exp2 one
// bit per stage, gain and sample product). Back-pressure on the output stalls
// the whole pipeline.
`include "distance_amplitude_panner_assert.svh"

module distance_amplitude_panner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[3:0], pos_x[19:4], pos_y[35:20], pos_z[51:36], device_channel[57:52],
	// sample[81:58], frame_index[93:82], zero fill
	input  logic [95:0] s_tdata,
	// action
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// target_channel[5:0], target_frame[17:6], contribution[41:18], gain[57:42],
	// zero fill
	output logic [63:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int IW      = dap_pkg::IDX_W;
	localparam int MS      = dap_pkg::MAX_SPEAKERS;
	localparam int NSQ     = 9;
	localparam int ST_SQ0  = 3;
	localparam int ST_LOGP = ST_SQ0 + NSQ + 1;
	localparam int ST_SCL  = ST_LOGP + 17;
	localparam int ST_GAIN = ST_SCL + 17;
	localparam int NST     = ST_GAIN + 2;

	// Configuration registers.
	logic        enable_q;
	logic [11:0] focus_q;
	logic [4:0]  speaker_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b1;
			focus_q         <= 12'd256;
			speaker_count_q <= 5'd0;
		end else if (cfg_we) begin
			case (dap_pkg::reg_idx_t'(cfg_index))
				dap_pkg::REG_ENABLE: enable_q        <= cfg_data[0];
				dap_pkg::REG_FOCUS:  focus_q         <= cfg_data;
				dap_pkg::REG_COUNT:  speaker_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Input fields.
	logic [3:0]         in_slot;
	logic signed [15:0] in_x, in_y, in_z;
	logic [5:0]         in_chan;
	logic signed [23:0] in_sample;
	logic [11:0]        in_frame;

	assign in_slot   = s_tdata[3:0];
	assign in_x      = s_tdata[19:4];
	assign in_y      = s_tdata[35:20];
	assign in_z      = s_tdata[51:36];
	assign in_chan   = s_tdata[57:52];
	assign in_sample = s_tdata[81:58];
	assign in_frame  = s_tdata[93:82];

	// Speaker tables, undefined until loaded.
	logic signed [15:0] spk_x_q [MS];
	logic signed [15:0] spk_y_q [MS];
	logic signed [15:0] spk_z_q [MS];
	logic [5:0]         spk_chan_q [MS];

	logic adv, s_acc, issue;
	logic busy_q;
	logic [IW-1:0] idx_q, last_q;
	logic signed [15:0] src_x_q, src_y_q, src_z_q;
	logic signed [23:0] sample_q;
	logic [11:0] frame_q;
	logic [IW:0] count_sat;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && s_tready;
	assign issue    = busy_q && adv;

	always_comb begin
		if (int'(speaker_count_q) > MS) count_sat = (IW + 1)'(MS);
		else count_sat = (IW + 1)'(speaker_count_q);
	end

	always_ff @(posedge clk) begin
		if (s_acc && dap_pkg::action_t'(s_tuser) == dap_pkg::ACT_LOAD
				&& int'(in_slot) < MS) begin
			spk_x_q[in_slot[IW-1:0]]    <= in_x;
			spk_y_q[in_slot[IW-1:0]]    <= in_y;
			spk_z_q[in_slot[IW-1:0]]    <= in_z;
			spk_chan_q[in_slot[IW-1:0]] <= in_chan;
		end
		if (s_acc) begin
			src_x_q  <= in_x;
			src_y_q  <= in_y;
			src_z_q  <= in_z;
			sample_q <= in_sample;
			frame_q  <= in_frame;
		end
	end

	// Speaker sequencer: one speaker enters the pipeline per advancing cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
		end else if (s_acc) begin
			if (dap_pkg::action_t'(s_tuser) == dap_pkg::ACT_RENDER && count_sat != '0) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				last_q <= IW'(count_sat - 1'b1);
			end
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == last_q) busy_q <= 1'b0;
		end
	end

	// Side information shifting along with the datapath.
	dap_pkg::meta_t meta_s [1:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NST; i++) meta_s[i] <= '0;
		end else if (adv) begin
			meta_s[1] <= '{valid: issue, chan: spk_chan_q[idx_q], frame: frame_q,
				sample: sample_q, last: idx_q == last_q};
			for (int i = 2; i <= NST; i++) meta_s[i] <= meta_s[i-1];
		end
	end

	// Differences and squares.
	logic signed [16:0] dx_s1, dy_s1, dz_s1;
	logic signed [33:0] sqx_s2, sqy_s2, sqz_s2;
	dap_pkg::sqrt_t     sqrt_s [0:NSQ];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= 17'(src_x_q) - 17'(spk_x_q[idx_q]);
			dy_s1  <= 17'(src_y_q) - 17'(spk_y_q[idx_q]);
			dz_s1  <= 17'(src_z_q) - 17'(spk_z_q[idx_q]);
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			sqz_s2 <= dz_s1 * dz_s1;
			// The sum of three squares can exceed the signed range of one square.
			sqrt_s[0].rad  <= 36'($unsigned(sqx_s2)) + 36'($unsigned(sqy_s2))
				+ 36'($unsigned(sqz_s2));
			sqrt_s[0].rem  <= '0;
			sqrt_s[0].root <= '0;
			for (int j = 1; j <= NSQ; j++) sqrt_s[j] <= dap_pkg::sqrt_step(sqrt_s[j-1]);
		end
	end

	// Log2 of (1 + distance / 256): normalise, then one fraction bit per squaring.
	logic [18:0] amp_a;
	logic [4:0]  amp_e;
	logic [30:0] lm_s [0:16];
	logic [15:0] lf_s [0:16];
	logic [3:0]  le_s [0:16];

	always_comb begin
		amp_a = 19'd256 + 19'(sqrt_s[NSQ].root);
		amp_e = 5'd8;
		for (int i = 8; i < 19; i++) begin
			if (amp_a[i]) amp_e = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lm_s[0] <= 31'({12'd0, amp_a} << (5'd30 - amp_e));
			lf_s[0] <= '0;
			le_s[0] <= 4'(amp_e - 5'd8);
		end
	end

	for (genvar k = 1; k <= 16; k++) begin : g_log
		logic [61:0] sq;
		logic [31:0] sh;
		assign sq = lm_s[k-1] * lm_s[k-1];
		assign sh = sq[61:30];
		always_ff @(posedge clk) begin
			if (adv) begin
				le_s[k] <= le_s[k-1];
				if (sh[31]) begin
					lm_s[k] <= sh[31:1];
					lf_s[k] <= lf_s[k-1] | (16'd1 << (16 - k));
				end else begin
					lm_s[k] <= sh[30:0];
					lf_s[k] <= lf_s[k-1];
				end
			end
		end
	end

	// Exponent scaled by focus, then exp2 by one root factor per fraction bit.
	logic [31:0] scaled;
	logic [30:0] ep_s [0:16];
	logic [15:0] ef_s [0:16];
	logic [3:0]  en_s [0:16];
	logic        ez_s [0:16];

	assign scaled = 32'({le_s[16], lf_s[16]} * focus_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			ep_s[0] <= 31'd1 << 30;
			ef_s[0] <= scaled[23:8];
			en_s[0] <= scaled[27:24];
			ez_s[0] <= |scaled[31:28];
		end
	end

	for (genvar k = 1; k <= 16; k++) begin : g_exp
		localparam logic [30:0] ROOT = dap_pkg::exp_root(k);
		logic [61:0] pr;
		assign pr = ep_s[k-1] * ROOT;
		always_ff @(posedge clk) begin
			if (adv) begin
				ef_s[k] <= ef_s[k-1];
				en_s[k] <= en_s[k-1];
				ez_s[k] <= ez_s[k-1];
				ep_s[k] <= ef_s[k-1][16-k] ? pr[60:30] : ep_s[k-1];
			end
		end
	end

	// Gain, product and saturation.
	logic [31:0]        gsum, gshift;
	logic [15:0]        gain_s47, gain_s48, gain_s49;
	logic signed [41:0] prod_s48;
	logic signed [26:0] quo;
	logic signed [23:0] contrib_s49;

	assign gsum   = 32'(ep_s[16]) + (32'd1 << (5'd14 + 5'(en_s[16])));
	assign gshift = gsum >> (5'd15 + 5'(en_s[16]));
	assign quo    = 27'(prod_s48 >>> 15);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!enable_q) gain_s47 <= 16'd32768;
			else if (ez_s[16]) gain_s47 <= '0;
			else gain_s47 <= gshift[15:0];
			prod_s48 <= 42'($signed({1'b0, gain_s47}) * $signed(meta_s[ST_GAIN].sample))
				+ 42'sd16384;
			gain_s48 <= gain_s47;
			gain_s49 <= gain_s48;
			if (quo > 27'sd8388607) contrib_s49 <= 24'sh7FFFFF;
			else if (quo < -27'sd8388608) contrib_s49 <= 24'sh800000;
			else contrib_s49 <= quo[23:0];
		end
	end

	assign m_tvalid = meta_s[NST].valid;
	assign m_tlast  = meta_s[NST].last;
	assign m_tdata  = {6'd0, gain_s49, contrib_s49, meta_s[NST].frame, meta_s[NST].chan};

	`DAP_ASSERT_NOW(a_gain_range, clk, arst_n, m_tvalid, m_tdata[57:42] <= 16'd32768)
	`DAP_ASSERT_NOW(a_idx_bound, clk, arst_n, busy_q, idx_q <= last_q)
	`DAP_ASSERT_NEXT(a_issue_valid, clk, arst_n, busy_q && adv, meta_s[1].valid)

endmodule

// File: tb/sv/tb_distance_amplitude_panner.sv
// ---------------------------------------------------------------------------
// tb_distance_amplitude_panner
// Self-checking bench for the distance amplitude panner. Speaker loads and
// render requests are streamed in with random gaps and output back-pressure.
// A behavioural gain model predicts every per-speaker result, and each result
// is compared field by field in order. The run steps through several register
// settings, written only while the block is drained.
// ---------------------------------------------------------------------------
module tb_distance_amplitude_panner;

	typedef struct {
		dap_pkg::action_t   act;
		logic [3:0]         slot;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [5:0]         chan;
		logic signed [23:0] smp;
		logic [11:0]        frame;
	} request_t;

	typedef struct {
		logic [5:0]  chan;
		logic [11:0] frame;
		logic [23:0] contrib;
		logic [15:0] gain;
		logic        last;
	} contribution_t;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	request_t      pending_q[$];
	contribution_t expected_q[$];
	request_t      cur;
	int            errors = 0;
	int            send_idle = 29;
	int            recv_idle = 67;
	int            idle_cycles = 0;
	int            hold_left = 0;
	logic          hold_req = 1'b0;

	// Shadow of the register file and the speaker tables.
	logic               gain_on = 1'b1;
	logic [11:0]        focus_val = 12'd256;
	logic [4:0]         spk_count = '0;
	logic signed [15:0] spk_x[dap_pkg::MAX_SPEAKERS];
	logic signed [15:0] spk_y[dap_pkg::MAX_SPEAKERS];
	logic signed [15:0] spk_z[dap_pkg::MAX_SPEAKERS];
	logic [5:0]         spk_chan[dap_pkg::MAX_SPEAKERS];

	distance_amplitude_panner dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2(a / 256) in Q.16 by repeated squaring of the mantissa.
	function automatic longint unsigned log2_fix(longint unsigned a);
		int              e;
		longint unsigned m;
		longint unsigned frac;
		e = 0;
		frac = 0;
		while ((a >> (e + 1)) != 0) e++;
		m = a << (30 - e);
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | (64'd1 << k);
			end
		end
		return (longint'(e - 8) << 16) | frac;
	endfunction

	function automatic logic [15:0] speaker_gain(request_t r, int s);
		longint          dx, dy, dz;
		longint unsigned sq, ex, n, f, p, rt;
		dx = longint'(r.px) - longint'(spk_x[s]);
		dy = longint'(r.py) - longint'(spk_y[s]);
		dz = longint'(r.pz) - longint'(spk_z[s]);
		sq = dx * dx + dy * dy + dz * dz;
		ex = (log2_fix(256 + int_sqrt(sq)) * focus_val) >> 8;
		n = ex >> 16;
		f = ex & 64'hFFFF;
		if (n >= 16) return 16'd0;
		p = 64'd1 << 30;
		rt = int_sqrt(64'd1 << 59);
		for (int k = 1; k <= 16; k++) begin
			if ((f >> (16 - k)) & 1) p = (p * rt) >> 30;
			rt = int_sqrt(rt << 30);
		end
		return 16'((p + (64'd1 << (14 + n))) >> (15 + n));
	endfunction

	// Applies one accepted request to the shadow state and queues its results.
	task automatic predict_contributions(request_t r);
		int            cnt;
		logic [15:0]   g;
		longint        t;
		contribution_t c;
		if (r.act == dap_pkg::ACT_LOAD) begin
			spk_x[r.slot] = r.px;
			spk_y[r.slot] = r.py;
			spk_z[r.slot] = r.pz;
			spk_chan[r.slot] = r.chan;
			return;
		end
		cnt = (spk_count > dap_pkg::MAX_SPEAKERS) ? dap_pkg::MAX_SPEAKERS : spk_count;
		for (int i = 0; i < cnt; i++) begin
			g = gain_on ? speaker_gain(r, i) : 16'd32768;
			t = (longint'(g) * longint'(r.smp) + 16384) >>> 15;
			if (t > 8388607) t = 8388607;
			if (t < -8388608) t = -8388608;
			c.chan = spk_chan[i];
			c.frame = r.frame;
			c.contrib = 24'(t);
			c.gain = g;
			c.last = (i + 1 == cnt);
			expected_q.push_back(c);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_contributions(cur);
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur.act;
					s_tdata <= {2'b00, cur.frame, cur.smp, cur.chan, cur.pz, cur.py,
						cur.px, cur.slot};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor, receiver stalls and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 0);
				end else begin
					contribution_t e;
					e = expected_q.pop_front();
					if (m_tdata[5:0] !== e.chan)
						report_mismatch("target_channel", m_tdata[5:0], e.chan);
					if (m_tdata[17:6] !== e.frame)
						report_mismatch("target_frame", m_tdata[17:6], e.frame);
					if (m_tdata[41:18] !== e.contrib)
						report_mismatch("contribution", m_tdata[41:18], e.contrib);
					if (m_tdata[57:42] !== e.gain)
						report_mismatch("gain", m_tdata[57:42], e.gain);
					if (m_tlast !== e.last)
						report_mismatch("last", m_tlast, e.last);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("tb_distance_amplitude_panner: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			// A long hold-off lets the pipeline fill and back up into the input.
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req <= 1'b0;
				hold_left <= 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(dap_pkg::reg_idx_t idx, logic [11:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			dap_pkg::REG_ENABLE: gain_on = val[0];
			dap_pkg::REG_FOCUS:  focus_val = val;
			dap_pkg::REG_COUNT:  spk_count = val[4:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(logic en, logic [11:0] foc, logic [4:0] cnt);
		write_reg(dap_pkg::REG_ENABLE, en);
		write_reg(dap_pkg::REG_FOCUS, foc);
		write_reg(dap_pkg::REG_COUNT, cnt);
	endtask

	function automatic logic signed [15:0] rand_pos();
		// Mostly near the origin so that gains stay well away from zero.
		if ($urandom_range(3) == 0) return 16'($urandom);
		return $signed(16'($urandom_range(2047))) - 16'sd1024;
	endfunction

	function automatic request_t rand_request();
		request_t r;
		r.act = ($urandom_range(3) == 0) ? dap_pkg::ACT_LOAD : dap_pkg::ACT_RENDER;
		r.slot = 4'($urandom);
		r.px = rand_pos();
		r.py = rand_pos();
		r.pz = rand_pos();
		r.chan = 6'($urandom);
		r.smp = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 24'sh7FFFFF : 24'sh800000)
			: 24'($urandom);
		r.frame = 12'($urandom);
		return r;
	endfunction

	function automatic request_t make_req(dap_pkg::action_t a, int sl, int x, int y, int z,
		int ch, int sm, int fr);
		request_t r;
		r.act = a;
		r.slot = 4'(sl);
		r.px = 16'(x);
		r.py = 16'(y);
		r.pz = 16'(z);
		r.chan = 6'(ch);
		r.smp = 24'(sm);
		r.frame = 12'(fr);
		return r;
	endfunction

	initial begin
		static logic        en_tab[7]  = '{1, 0, 1, 1, 1, 1, 1};
		static logic [11:0] foc_tab[7] = '{256, 256, 0, 4095, 128, 700, 1024};
		static logic [4:0]  cnt_tab[7] = '{16, 5, 16, 1, 31, 0, 8};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a render with no speakers, every slot loaded, then extremes.
		pending_q.push_back(make_req(dap_pkg::ACT_RENDER, 0, 0, 0, 0, 0, 1000, 1));
		for (int s = 0; s < dap_pkg::MAX_SPEAKERS; s++)
			pending_q.push_back(make_req(dap_pkg::ACT_LOAD, s, (s % 2) ? -32768 : 32767,
				s * 256, (s == 3) ? -32768 : 0, (s == 5) ? 63 : s, 0, 0));
		drain();
		setup(1, 256, 16);
		pending_q.push_back(make_req(dap_pkg::ACT_RENDER, 0, 32767, 0, 0, 0, 8388607, 4095));
		pending_q.push_back(make_req(dap_pkg::ACT_RENDER, 0, -32768, -32768, -32768, 0,
			-8388608, 0));
		pending_q.push_back(make_req(dap_pkg::ACT_RENDER, 0, 32767, 32767, 32767, 0, -1,
			2048));
		pending_q.push_back(make_req(dap_pkg::ACT_RENDER, 0, 0, 0, 0, 0, 1, 7));
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			send_idle = (ph < 3) ? 29 : (ph < 5) ? 67 : 0;
			recv_idle = (ph < 3) ? 67 : (ph < 5) ? 29 : 0;
			setup(en_tab[ph], foc_tab[ph], cnt_tab[ph]);
			if (ph == 2) hold_req <= 1'b1;
			for (int i = 0; i < 28; i++) pending_q.push_back(rand_request());
			// Sender pause until everything outstanding has come back.
			if (ph == 4) drain();
			for (int i = 0; i < 28; i++) pending_q.push_back(rand_request());
			drain();
		end

		if (errors == 0) begin
			$display("tb_distance_amplitude_panner: clean");
		end else begin
			$display("tb_distance_amplitude_panner: errors");
		end
		$finish;
	end

endmodule
